>>> src/spow_pkg.sv
// Package: SHA-256 constants, round functions and shared types for the score check block.
package spow_pkg;

    localparam int NumRounds  = 64;
    localparam int RndW       = 6;
    localparam int ScoreW     = 16;
    localparam int DiffW      = 16;
    localparam int CfgIdxW    = 3;
    localparam int NumDataWords = 4;
    localparam logic [31:0] PadWord13 = 32'h0000_0080;
    localparam logic [31:0] LenWord   = 32'd440;   // 55 bytes * 8

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DIFFICULTY = 3'd0,
        CFG_DATA_0     = 3'd1,
        CFG_DATA_1     = 3'd2,
        CFG_DATA_2     = 3'd3,
        CFG_DATA_3     = 3'd4
    } cfg_idx_t;

    typedef logic [31:0] word_t;

    // working variables a..h plus message schedule window
    typedef struct packed {
        word_t [7:0]  v;
        word_t [15:0] w;
    } rnd_state_t;

    typedef struct packed {
        logic  valid;
        word_t [7:0] h;
    } digest_t;

    localparam word_t [7:0] InitH = '{
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t round_k(input logic [RndW-1:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t ror(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> src/spow_if.sv
// Valid/ready channel interfaces for nonce input, score output and config writes.
interface spow_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] nonce_word_0;
    logic [63:0] nonce_word_1;
    logic [55:0] nonce_word_2;
    modport source (output valid, nonce_word_0, nonce_word_1, nonce_word_2, input ready);
    modport sink   (input valid, nonce_word_0, nonce_word_1, nonce_word_2, output ready);
endinterface

interface spow_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] score;
    logic        passed;
    modport source (output valid, score, passed, input ready);
    modport sink   (input valid, score, passed, output ready);
endinterface

interface spow_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/spow_round_cell.sv
// One SHA-256 round cell: one compression round and one schedule step, registered.
module spow_round_cell
    import spow_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [RndW-1:0] round_idx,
    input  logic            valid_in,
    input  rnd_state_t      state_in,
    output logic            valid_out,
    output rnd_state_t      state_out
);

    logic       valid_reg;
    rnd_state_t state_reg, state_next;
    word_t a, e, t1, t2, s0, s1, wn;

    always_comb
    begin
        a  = state_in.v[0];
        e  = state_in.v[4];
        t1 = state_in.v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
           + ((e & state_in.v[5]) ^ (~e & state_in.v[6]))
           + round_k(round_idx) + state_in.w[0];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
           + ((a & state_in.v[1]) ^ (a & state_in.v[2]) ^ (state_in.v[1] & state_in.v[2]));
        s0 = ror(state_in.w[1], 7) ^ ror(state_in.w[1], 18) ^ (state_in.w[1] >> 3);
        s1 = ror(state_in.w[14], 17) ^ ror(state_in.w[14], 19) ^ (state_in.w[14] >> 10);
        wn = state_in.w[0] + s0 + state_in.w[9] + s1;
        state_next.v[0] = t1 + t2;
        state_next.v[1] = state_in.v[0];
        state_next.v[2] = state_in.v[1];
        state_next.v[3] = state_in.v[2];
        state_next.v[4] = state_in.v[3] + t1;
        state_next.v[5] = state_in.v[4];
        state_next.v[6] = state_in.v[5];
        state_next.v[7] = state_in.v[6];
        // schedule window slides by one word
        for (int i = 0; i < 15; i++)
        begin
            state_next.w[i] = state_in.w[i+1];
        end
        state_next.w[15] = wn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

>>> src/spow_scorer.sv
// Digest scoring stage: leading-zero count, fraction and difficulty compare, registered.
module spow_scorer
    import spow_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  digest_t           dig,
    input  logic [DiffW-1:0]  difficulty,
    output logic              valid,
    output logic [ScoreW-1:0] score,
    output logic              passed
);

    logic [255:0]      bits;
    logic [247:0]      scan;
    logic [7:0]        lz_cnt;
    logic [7:0]        frac;
    logic              found;
    logic [ScoreW-1:0] score_next;
    logic              valid_reg;
    logic [ScoreW-1:0] score_reg;
    logic              passed_reg;

    always_comb
    begin
        bits   = {dig.h[0], dig.h[1], dig.h[2], dig.h[3], dig.h[4], dig.h[5], dig.h[6], dig.h[7]};
        scan   = bits[255:8];
        lz_cnt = 8'd248;
        found  = 1'b0;
        // priority encode from the top; the 8 bits after the first one follow it
        for (int i = 247; i >= 0; i--)
        begin
            if (!found && scan[i])
            begin
                found  = 1'b1;
                lz_cnt = 8'(247 - i);
            end
        end
        frac = 8'((bits << (1 + 32'(lz_cnt))) >> 248);
        if (!found)
        begin
            frac = '0;
        end
        score_next = {lz_cnt, frac};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= dig.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            score_reg  <= score_next;
            passed_reg <= score_next > difficulty;
        end
    end

    assign valid  = valid_reg;
    assign score  = score_reg;
    assign passed = passed_reg;

endmodule

>>> src/sha256_pow_score_check.sv
// Top level: proof-of-work score check, 64 round cells feeding a scoring stage.
//
//  channel | role   | fields
//  in      | sink   | nonce_word_0, nonce_word_1, nonce_word_2
//  out     | source | score, passed
//  cfg     | sink   | index, data (difficulty, data_word_0..3)
//
// One nonce per cycle while the output is not stalled; the path runs through 64 round cells,
// the digest add and scoring, each registered. The round-cell chain advances as one pipeline; it
// holds only when the output register is full and not taken. Reset clears all valid bits and config to 0.
// Config writes are always ready.
module sha256_pow_score_check
    import spow_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    spow_in_if.sink    in_ch,
    spow_out_if.source out_ch,
    spow_cfg_if.sink   cfg
);

    logic [DiffW-1:0]      difficulty_reg;
    logic [NumDataWords-1:0][63:0] data_reg;
    logic                  en;
    logic                  in_fire;
    logic [NumRounds:0]    vchain;
    rnd_state_t            schain [NumRounds+1];
    logic                  dig_valid_reg;
    word_t [7:0]           dig_h_reg;
    digest_t               dig;
    logic                  sc_valid;
    logic [ScoreW-1:0]     sc_score;
    logic                  sc_passed;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            difficulty_reg <= '0;
            data_reg       <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DIFFICULTY: difficulty_reg <= cfg.data[DiffW-1:0];
                CFG_DATA_0:     data_reg[0] <= cfg.data;
                CFG_DATA_1:     data_reg[1] <= cfg.data;
                CFG_DATA_2:     data_reg[2] <= cfg.data;
                CFG_DATA_3:     data_reg[3] <= cfg.data;
                default:        ;
            endcase
        end
    end

    // whole pipe moves unless the result at the end is stalled
    assign en          = !(out_ch.valid && !out_ch.ready);
    assign in_ch.ready = en;
    assign in_fire     = in_ch.valid && en;
    assign vchain[0]   = in_ch.valid;

    always_comb
    begin
        schain[0].v = InitH;
        for (int i = 0; i < NumDataWords; i++)
        begin
            schain[0].w[2*i]   = data_reg[i][63:32];
            schain[0].w[2*i+1] = data_reg[i][31:0];
        end
        schain[0].w[8]  = in_ch.nonce_word_0[63:32];
        schain[0].w[9]  = in_ch.nonce_word_0[31:0];
        schain[0].w[10] = in_ch.nonce_word_1[63:32];
        schain[0].w[11] = in_ch.nonce_word_1[31:0];
        schain[0].w[12] = in_ch.nonce_word_2[55:24];
        schain[0].w[13] = {in_ch.nonce_word_2[23:0], 8'h00} | PadWord13;
        schain[0].w[14] = '0;
        schain[0].w[15] = LenWord;
    end

    for (genvar r = 0; r < NumRounds; r++)
    begin : g_round
        spow_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .round_idx (RndW'(r)),
            .valid_in  (vchain[r]),
            .state_in  (schain[r]),
            .valid_out (vchain[r+1]),
            .state_out (schain[r+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dig_valid_reg <= vchain[NumRounds];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 8; i++)
            begin
                dig_h_reg[i] <= InitH[i] + schain[NumRounds].v[i];
            end
        end
    end

    assign dig.valid = dig_valid_reg;
    assign dig.h     = dig_h_reg;

    spow_scorer u_scorer (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .dig        (dig),
        .difficulty (difficulty_reg),
        .valid      (sc_valid),
        .score      (sc_score),
        .passed     (sc_passed)
    );

    assign out_ch.valid  = sc_valid;
    assign out_ch.score  = sc_score;
    assign out_ch.passed = sc_passed;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> out_ch.valid)
        else $error("stall without pending result");
    a_score_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.score <= 16'd63743)
        else $error("score out of range");
    a_pass_rel: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.passed |-> out_ch.score != 16'd0)
        else $error("zero score passed");
    a_no_take_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> in_ch.ready)
        else $error("input taken while stalled");

endmodule

>>> test/tb_top.sv
// Testbench for sha256_pow_score_check: SHA-256 score predictor, scoreboard and drivers.
`timescale 1ns / 100ps

class pow_score_board;
    typedef struct {
        bit [15:0] score;
        bit        passed;
    } verdict_t;

    static const bit [31:0] RoundConst[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    static const bit [31:0] StartHash[8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    bit [15:0] difficulty;
    bit [63:0] block_data[4];
    verdict_t  score_q[$];
    int        mismatches;
    int        scores_seen;
    int        passes_seen;
    int        best_score;

    function bit [31:0] rotr(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function bit [255:0] digest_of(bit [511:0] blk);
        bit [31:0] w[64];
        bit [31:0] v[8];
        bit [31:0] t1;
        bit [31:0] t2;
        bit [255:0] dig;
        for (int i = 0; i < 16; i++)
            w[i] = blk[511 - 32*i -: 32];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++)
            v[i] = StartHash[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            dig[255 - 32*i -: 32] = StartHash[i] + v[i];
        return dig;
    endfunction

    // zero bits over the first 31 bytes, then the 8 bits after the first one
    function verdict_t score_nonce(bit [63:0] n0, bit [63:0] n1, bit [55:0] n2);
        bit [255:0] dig;
        bit [7:0]   b;
        bit [15:0]  win;
        int         zeros;
        int         lz;
        bit [7:0]   frac;
        verdict_t   r;
        dig = digest_of({block_data[0], block_data[1], block_data[2], block_data[3],
                         n0, n1, n2, 8'h80, 32'h0, 32'd440});
        zeros = 0;
        frac = 0;
        for (int i = 0; i < 31; i++)
        begin
            b = dig[255 - 8*i -: 8];
            if (b == 0)
                zeros += 8;
            else
            begin
                lz = 0;
                while (b[7 - lz] == 1'b0)
                    lz++;
                zeros += lz;
                win = {b, dig[247 - 8*i -: 8]};
                frac = 8'(win >> (7 - lz));
                break;
            end
        end
        r.score = 16'(zeros * 256) + 16'(frac);
        r.passed = r.score > difficulty;
        return r;
    endfunction

    function void note_nonce(bit [63:0] n0, bit [63:0] n1, bit [55:0] n2);
        score_q.push_back(score_nonce(n0, n1, n2));
    endfunction

    task report(string what);
        mismatches++;
        $display("%0t: mismatch: %s", $realtime, what);
    endtask

    task check_result(bit [15:0] score, bit passed);
        verdict_t e;
        if (score_q.size() == 0)
        begin
            report($sformatf("unexpected score %0d", score));
            return;
        end
        e = score_q.pop_front();
        scores_seen++;
        if (passed)
            passes_seen++;
        if (score > best_score)
            best_score = score;
        if (score !== e.score)
            report($sformatf("score %0d, expected %0d", score, e.score));
        if (passed !== e.passed)
            report($sformatf("passed %0b, expected %0b (score %0d)", passed, e.passed, e.score));
    endtask
endclass

module tb_top;
    import spow_pkg::*;

    logic clk;
    logic rst_n;
    bit   no_idle;
    bit   want_stall;
    int   stall_left;
    int   quiet_cycles;
    int   hold_offs;
    pow_score_board board;

    spow_in_if  in_ch();
    spow_out_if out_ch();
    spow_cfg_if cfg();

    sha256_pow_score_check u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.nonce_word_0 = '0;
        in_ch.nonce_word_1 = '0;
        in_ch.nonce_word_2 = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_DIFFICULTY;
        cfg.data = '0;
    end

    always #5 clk = ~clk;

    // result receiver: random backpressure plus one long hold-off
    always @(posedge clk)
    begin
        if (want_stall)
        begin
            want_stall = 1'b0;
            stall_left = 300;
            hold_offs++;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= rst_n && (no_idle || $urandom_range(99) >= 27);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                board.note_nonce(in_ch.nonce_word_0, in_ch.nonce_word_1, in_ch.nonce_word_2);
            if (out_ch.valid && out_ch.ready)
                board.check_result(out_ch.score, out_ch.passed);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 5000)
            begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    task write_reg(cfg_idx_t idx, logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_DIFFICULTY)
            board.difficulty = value[15:0];
        else
            board.block_data[idx - CFG_DATA_0] = value;
    endtask

    task send_nonce(logic [63:0] n0, logic [63:0] n1, logic [55:0] n2);
        while (!no_idle && $urandom_range(99) < 27)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.nonce_word_0 <= n0;
        in_ch.nonce_word_1 <= n1;
        in_ch.nonce_word_2 <= n2;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        while (board.score_q.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    function logic [63:0] rand64();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task configure(logic [15:0] diff, logic [63:0] d0, logic [63:0] d1,
                   logic [63:0] d2, logic [63:0] d3);
        write_reg(CFG_DIFFICULTY, {48'h0, diff});
        write_reg(CFG_DATA_0, d0);
        write_reg(CFG_DATA_1, d1);
        write_reg(CFG_DATA_2, d2);
        write_reg(CFG_DATA_3, d3);
    endtask

    initial
    begin
        logic [15:0] diff;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero and all-ones data and nonces, difficulty at both extremes, then mixed data at 0x00ff
        configure(16'h0, '0, '0, '0, '0);
        send_nonce('0, '0, '0);
        send_nonce('1, '1, '1);
        send_nonce(64'h8000_0000_0000_0000, 64'h1, 56'h80_0000_0000_0000);
        send_nonce(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 56'h1);
        for (int i = 0; i < 6; i++)
            send_nonce(rand64(), rand64(), 56'(rand64()));
        drain();
        configure(16'hffff, '1, '1, '1, '1);
        send_nonce('0, '0, '0);
        send_nonce('1, '1, '1);
        for (int i = 0; i < 4; i++)
            send_nonce(rand64(), rand64(), 56'(rand64()));
        drain();
        configure(16'h00ff, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff,
                  64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe);
        for (int i = 0; i < 8; i++)
            send_nonce(64'(i), 64'(i * 3), 56'(i << 40));
        drain();

        // random phases at several difficulty thresholds
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: diff = 16'd0;
                1: diff = 16'd255;
                2: diff = 16'hffff;
                default: diff = 16'($urandom_range(1023));
            endcase
            configure(diff, rand64(), rand64(), rand64(), rand64());
            no_idle = (ph == 2);
            for (int i = 0; i < 166; i++)
            begin
                if (ph == 3 && i == 40)
                    want_stall = 1'b1;
                send_nonce(rand64(), rand64(), 56'(rand64()));
            end
            no_idle = 1'b0;
            drain();
        end

        $display("covered %0d scores (%0d passing, best %0d) over 8 settings, %0d hold-off(s)",
                 board.scores_seen, board.passes_seen, board.best_score, hold_offs);
        $display("mismatches: %0d", board.mismatches);
        if (board.mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
